// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/jlex_pkg.sv =====
// ----------------------------------------------------------------------------
// jlex_pkg
// types, codes and character classes of the json byte stream lexer
// ----------------------------------------------------------------------------
package jlex_pkg;

   // lexer modes
   localparam logic [3:0] MODE_IDLE  = 4'd0;
   localparam logic [3:0] MODE_WS    = 4'd1;
   localparam logic [3:0] MODE_DIGIT = 4'd2;
   localparam logic [3:0] MODE_IDENT = 4'd3;
   localparam logic [3:0] MODE_SLASH = 4'd4;
   localparam logic [3:0] MODE_STR   = 4'd5;
   localparam logic [3:0] MODE_ESC   = 4'd6;
   localparam logic [3:0] MODE_HEX   = 4'd7;
   localparam logic [3:0] MODE_OCT   = 4'd8;

   // event kinds
   localparam logic [1:0] EV_CHAR  = 2'd0;
   localparam logic [1:0] EV_CLOSE = 2'd1;
   localparam logic [1:0] EV_DROP  = 2'd2;

   // token kinds
   localparam logic [2:0] TOK_SPACE = 3'd0;
   localparam logic [2:0] TOK_IDENT = 3'd1;
   localparam logic [2:0] TOK_PUNCT = 3'd2;
   localparam logic [2:0] TOK_DIGIT = 3'd3;
   localparam logic [2:0] TOK_STR   = 3'd4;

   // characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_USCORE = 8'h5f;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_UP_F   = 8'h46;

   // most results one item can cause
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned OCT_DIGITS  = 3;

   typedef struct packed {
      logic [1:0] ev;
      logic [2:0] kind;
      logic [7:0] ch;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   n;
      rsp_item_type r0;
      rsp_item_type r1;
      logic [3:0]   mode;
      logic         quote_load;
      logic         quote;
   } idle_out_type;

   typedef struct packed {
      logic push_char;
      logic push_close;
      logic to_esc;
   } str_out_type;

   function automatic rsp_item_type mk_item(logic [1:0] ev, logic [2:0] kind, logic [7:0] ch);
      rsp_item_type r;
      r.ev   = ev;
      r.kind = kind;
      r.ch   = ch;
      return r;
   endfunction

   function automatic logic is_ws(logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   function automatic logic is_ident_start(logic [7:0] c);
      return is_alpha(c) || c == CH_USCORE || c == CH_DOLLAR;
   endfunction

   function automatic logic is_oct(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h37;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= CH_UP_F);
   endfunction

   // letters a-f and A-F share the low nibble 1..6
   function automatic logic [3:0] hex_val(logic [7:0] c);
      return is_dig(c) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   // byte seen with no token open
   function automatic idle_out_type idle_step(logic [7:0] c);
      idle_out_type o;
      o = '0;
      o.mode = MODE_IDLE;
      if (is_ws(c)) begin
         o.n    = 2'd1;
         o.r0   = mk_item(EV_CHAR, TOK_SPACE, c);
         o.mode = MODE_WS;
      end else if (is_dig(c)) begin
         o.n    = 2'd1;
         o.r0   = mk_item(EV_CHAR, TOK_DIGIT, c);
         o.mode = MODE_DIGIT;
      end else if (is_ident_start(c)) begin
         o.n    = 2'd1;
         o.r0   = mk_item(EV_CHAR, TOK_IDENT, c);
         o.mode = MODE_IDENT;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         o.quote_load = 1'b1;
         o.quote      = (c == CH_SQUOTE);
         o.mode       = MODE_STR;
      end else if (c == CH_SLASH) begin
         o.mode = MODE_SLASH;
      end else if (is_punct(c)) begin
         o.n  = 2'd2;
         o.r0 = mk_item(EV_CHAR, TOK_PUNCT, c);
         o.r1 = mk_item(EV_CLOSE, TOK_PUNCT, 8'd0);
      end
      return o;
   endfunction

   // plain byte inside a string
   function automatic str_out_type str_step(logic [7:0] c, logic quote_single);
      str_out_type o;
      o = '0;
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         o.push_close = ((c == CH_SQUOTE) == quote_single);
      end else if (c == CH_BSLASH) begin
         o.to_esc = 1'b1;
      end else begin
         o.push_char = 1'b1;
      end
      return o;
   endfunction

endpackage

// ===== rtl/core/jlex_ifs.sv =====
// ----------------------------------------------------------------------------
// jlex channel interfaces
// byte input channel and lexer event channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface jlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_mark;

   modport source (output valid, output byte_in, output end_mark, input ready);
   modport sink (input valid, input byte_in, input end_mark, output ready);
endinterface

interface jlex_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [2:0] token_kind;
   logic [7:0] char_value;
   logic       last_of_run;

   modport source (output valid, output event_kind, output token_kind,
                   output char_value, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input token_kind,
                 input char_value, input last_of_run, output ready);
endinterface

// ===== rtl/core/json_lexer_byte_stream_core.sv =====
// ----------------------------------------------------------------------------
// json_lexer_byte_stream_core
// byte-at-a-time lexer: each byte or end mark gives zero to four token events
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_bus   in   valid/ready   byte_in, end_mark
//  rsp_bus   out  valid/ready   event_kind, token_kind, char_value, last_of_run
//
//  an item is decoded combinationally from the input register into the result list
//  the result list drains one event per cycle while rsp_bus is ready; most bytes give
//  one event and stream at one item per cycle while the output does not stall
//  the input register takes the next item while the list still drains
//  synchronous active-high reset clears lexer state and both registers' valids
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_lexer_byte_stream_core (
   input logic        clock,
   input logic        reset,
   jlex_req_if.sink   req_bus,
   jlex_rsp_if.source rsp_bus
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // lexer state
   logic [3:0] mode_ff, mode_in;
   logic       quote_ff, quote_in;
   logic [7:0] esc_ff, esc_in;
   logic [1:0] oct_cnt_ff, oct_cnt_in;

   // result list
   jlex_pkg::rsp_item_type list_ff [jlex_pkg::MAX_RESULTS];
   jlex_pkg::rsp_item_type list_in [jlex_pkg::MAX_RESULTS];
   logic [2:0] count_ff, count_in;
   logic [1:0] idx_ff;

   jlex_pkg::idle_out_type idl;
   jlex_pkg::str_out_type  sto;
   jlex_pkg::rsp_item_type cur;
   logic do_idle, do_str;
   logic rsp_fire, is_last, consume;
   logic [7:0] c;
   logic [7:0] oct_val;
   logic [7:0] hex_next;

   assign c        = in_byte_ff;
   assign idl      = jlex_pkg::idle_step(c);
   assign sto      = jlex_pkg::str_step(c, quote_ff);
   assign oct_val  = {esc_ff[4:0], c[2:0]};
   assign hex_next = {esc_ff[3:0], jlex_pkg::hex_val(c)};

   assign cur      = list_ff[idx_ff];
   assign is_last  = ({1'b0, idx_ff} == count_ff - 3'd1);
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign consume  = in_valid_ff && (count_ff == 3'd0 || (rsp_fire && is_last));

   assign req_bus.ready       = !in_valid_ff || consume;
   assign rsp_bus.valid       = (count_ff != 3'd0);
   assign rsp_bus.event_kind  = cur.ev;
   assign rsp_bus.token_kind  = cur.kind;
   assign rsp_bus.char_value  = cur.ch;
   assign rsp_bus.last_of_run = is_last;

   // decode one item into the event list and the next lexer state
   always_comb begin
      list_in    = '{default: '0};
      count_in   = 3'd0;
      mode_in    = mode_ff;
      quote_in   = quote_ff;
      esc_in     = esc_ff;
      oct_cnt_in = oct_cnt_ff;
      do_idle    = 1'b0;
      do_str     = 1'b0;
      if (in_end_ff) begin
         case (mode_ff)
            jlex_pkg::MODE_WS: begin
               list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_SPACE, 8'd0);
               count_in   = 3'd1;
            end
            jlex_pkg::MODE_DIGIT: begin
               list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_DIGIT, 8'd0);
               count_in   = 3'd1;
            end
            jlex_pkg::MODE_IDENT: begin
               list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_IDENT, 8'd0);
               count_in   = 3'd1;
            end
            jlex_pkg::MODE_SLASH: begin
               list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_PUNCT,
                                              jlex_pkg::CH_SLASH);
               list_in[1] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_PUNCT, 8'd0);
               count_in   = 3'd2;
            end
            jlex_pkg::MODE_STR, jlex_pkg::MODE_ESC, jlex_pkg::MODE_HEX,
            jlex_pkg::MODE_OCT: begin
               list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_DROP, jlex_pkg::TOK_STR, 8'd0);
               count_in   = 3'd1;
            end
            default: begin
            end
         endcase
         mode_in    = jlex_pkg::MODE_IDLE;
         quote_in   = 1'b0;
         esc_in     = 8'd0;
         oct_cnt_in = 2'd0;
      end else begin
         case (mode_ff)
            jlex_pkg::MODE_WS: begin
               if (jlex_pkg::is_ws(c)) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_SPACE, c);
                  count_in   = 3'd1;
               end else begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_SPACE, 8'd0);
                  count_in   = 3'd1;
                  do_idle    = 1'b1;
               end
            end
            jlex_pkg::MODE_DIGIT: begin
               if (jlex_pkg::is_dig(c)) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_DIGIT, c);
                  count_in   = 3'd1;
               end else begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_DIGIT, 8'd0);
                  count_in   = 3'd1;
                  do_idle    = 1'b1;
               end
            end
            jlex_pkg::MODE_IDENT: begin
               if (jlex_pkg::is_ident_start(c) || jlex_pkg::is_dig(c)) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_IDENT, c);
                  count_in   = 3'd1;
               end else begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_IDENT, 8'd0);
                  count_in   = 3'd1;
                  do_idle    = 1'b1;
               end
            end
            jlex_pkg::MODE_SLASH: begin
               mode_in = jlex_pkg::MODE_IDLE;
               // comment openers are swallowed, anything else makes a lone slash token
               if (c != jlex_pkg::CH_STAR && c != jlex_pkg::CH_SLASH) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_PUNCT,
                                                 jlex_pkg::CH_SLASH);
                  list_in[1] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_PUNCT, 8'd0);
                  count_in   = 3'd2;
                  do_idle    = 1'b1;
               end
            end
            jlex_pkg::MODE_STR: begin
               do_str = 1'b1;
            end
            jlex_pkg::MODE_ESC: begin
               mode_in  = jlex_pkg::MODE_STR;
               count_in = 3'd1;
               if (c == jlex_pkg::CH_LOW_N) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                                                 jlex_pkg::CH_LF);
               end else if (c == jlex_pkg::CH_LOW_R) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                                                 jlex_pkg::CH_CR);
               end else if (c == jlex_pkg::CH_LOW_T) begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                                                 jlex_pkg::CH_TAB);
               end else if (c == jlex_pkg::CH_LOW_X) begin
                  count_in   = 3'd0;
                  mode_in    = jlex_pkg::MODE_HEX;
                  esc_in     = 8'd0;
                  oct_cnt_in = 2'd0;
               end else if (jlex_pkg::is_oct(c)) begin
                  count_in   = 3'd0;
                  mode_in    = jlex_pkg::MODE_OCT;
                  esc_in     = {5'd0, c[2:0]};
                  oct_cnt_in = 2'd1;
               end else begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, c);
               end
            end
            jlex_pkg::MODE_HEX: begin
               if (jlex_pkg::is_hex(c)) begin
                  esc_in     = hex_next;
                  oct_cnt_in = 2'd1;
               end else begin
                  // no digit read: the escape stands for a plain x
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                                  (oct_cnt_ff != 2'd0) ? esc_ff : jlex_pkg::CH_LOW_X);
                  count_in   = 3'd1;
                  mode_in    = jlex_pkg::MODE_STR;
                  esc_in     = 8'd0;
                  oct_cnt_in = 2'd0;
                  do_str     = 1'b1;
               end
            end
            jlex_pkg::MODE_OCT: begin
               if (jlex_pkg::is_oct(c) && oct_cnt_ff < 2'(jlex_pkg::OCT_DIGITS)) begin
                  if (oct_cnt_ff == 2'(jlex_pkg::OCT_DIGITS - 1)) begin
                     list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                                                    oct_val);
                     count_in   = 3'd1;
                     mode_in    = jlex_pkg::MODE_STR;
                     esc_in     = 8'd0;
                     oct_cnt_in = 2'd0;
                  end else begin
                     esc_in     = oct_val;
                     oct_cnt_in = oct_cnt_ff + 2'd1;
                  end
               end else begin
                  list_in[0] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, esc_ff);
                  count_in   = 3'd1;
                  mode_in    = jlex_pkg::MODE_STR;
                  esc_in     = 8'd0;
                  oct_cnt_in = 2'd0;
                  do_str     = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // byte that falls through to the idle decoder
         if (do_idle) begin
            if (idl.n != 2'd0) begin
               list_in[count_in[1:0]] = idl.r0;
               count_in               = count_in + 3'd1;
            end
            if (idl.n == 2'd2) begin
               list_in[count_in[1:0]] = idl.r1;
               count_in               = count_in + 3'd1;
            end
            mode_in = idl.mode;
            if (idl.quote_load) begin
               quote_in = idl.quote;
            end
         end

         // byte handled as plain string content
         if (do_str) begin
            if (sto.push_char) begin
               list_in[count_in[1:0]] = jlex_pkg::mk_item(jlex_pkg::EV_CHAR,
                                                          jlex_pkg::TOK_STR, c);
               count_in               = count_in + 3'd1;
            end
            if (sto.push_close) begin
               list_in[count_in[1:0]] = jlex_pkg::mk_item(jlex_pkg::EV_CLOSE,
                                                          jlex_pkg::TOK_STR, 8'd0);
               count_in               = count_in + 3'd1;
               mode_in                = jlex_pkg::MODE_IDLE;
               quote_in               = 1'b0;
            end
            if (sto.to_esc) begin
               mode_in = jlex_pkg::MODE_ESC;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 3'd0;
         idx_ff      <= 2'd0;
         mode_ff     <= jlex_pkg::MODE_IDLE;
         quote_ff    <= 1'b0;
         esc_ff      <= 8'd0;
         oct_cnt_ff  <= 2'd0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (consume) begin
            count_ff   <= count_in;
            idx_ff     <= 2'd0;
            mode_ff    <= mode_in;
            quote_ff   <= quote_in;
            esc_ff     <= esc_in;
            oct_cnt_ff <= oct_cnt_in;
         end else if (rsp_fire) begin
            if (is_last) begin
               count_ff <= 3'd0;
               idx_ff   <= 2'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.byte_in;
         in_end_ff  <= req_bus.end_mark;
      end
      if (consume) begin
         list_ff <= list_in;
      end
   end

   `ASSERT_ALWAYS(a_idx_in_list, !rsp_bus.valid || ({1'b0, idx_ff} < count_ff),
                  "result index beyond list")
   `ASSERT_IMPLY(a_esc_clear, !(mode_ff == jlex_pkg::MODE_HEX || mode_ff == jlex_pkg::MODE_OCT),
                 esc_ff == 8'd0, "escape value left over outside an escape")
   `ASSERT_NEXT(a_end_resets, consume && in_end_ff,
                mode_ff == jlex_pkg::MODE_IDLE && !quote_ff,
                "lexer not idle after end of stream")
   `ASSERT_NEXT(a_run_continues, rsp_fire && !is_last, rsp_bus.valid,
                "multi-event item cut short")

endmodule

// ===== tb/jlex_event_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlex_event_monitor
// watches both channels of the lexer, predicts the event list of every
// accepted byte item and compares each accepted event in order
// ----------------------------------------------------------------------------
module jlex_event_monitor (
   input  logic        clock,
   input  logic        reset,
   jlex_req_if         req_bus,
   jlex_rsp_if         rsp_bus,
   output int unsigned events_pending,
   output int unsigned event_errors
);

   typedef struct packed {
      logic [1:0] ev;
      logic [2:0] kind;
      logic [7:0] ch;
      logic       last;
   } lex_event_type;

   lex_event_type expected_events[$];

   logic [3:0] lex_mode_q;
   logic       quote_single_q;
   logic [7:0] esc_acc_q;
   logic [1:0] esc_digits_q;

   function automatic logic blank_char(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic decimal_char(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic octal_char(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h37;
   endfunction

   function automatic logic name_lead(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
             c == jlex_pkg::CH_USCORE || c == jlex_pkg::CH_DOLLAR;
   endfunction

   function automatic logic mark_char(logic [7:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (decimal_char(c)) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= jlex_pkg::CH_UP_F) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   task automatic push_event(input logic [1:0] ev, input logic [2:0] kind,
                             input logic [7:0] ch);
      lex_event_type e;
      e.ev   = ev;
      e.kind = kind;
      e.ch   = ch;
      e.last = 1'b0;
      expected_events = {expected_events, e};
   endtask

   task automatic clear_lexer();
      lex_mode_q     = jlex_pkg::MODE_IDLE;
      quote_single_q = 1'b0;
      esc_acc_q      = 8'd0;
      esc_digits_q   = 2'd0;
   endtask

   // byte arriving with no token open
   task automatic open_token(input logic [7:0] c);
      if (blank_char(c)) begin
         push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_SPACE, c);
         lex_mode_q = jlex_pkg::MODE_WS;
      end else if (decimal_char(c)) begin
         push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_DIGIT, c);
         lex_mode_q = jlex_pkg::MODE_DIGIT;
      end else if (name_lead(c)) begin
         push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_IDENT, c);
         lex_mode_q = jlex_pkg::MODE_IDENT;
      end else if (c == jlex_pkg::CH_DQUOTE || c == jlex_pkg::CH_SQUOTE) begin
         quote_single_q = (c == jlex_pkg::CH_SQUOTE);
         lex_mode_q     = jlex_pkg::MODE_STR;
      end else if (c == jlex_pkg::CH_SLASH) begin
         lex_mode_q = jlex_pkg::MODE_SLASH;
      end else if (mark_char(c)) begin
         push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_PUNCT, c);
         push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_PUNCT, 8'd0);
      end
   endtask

   task automatic string_byte(input logic [7:0] c);
      if (c == jlex_pkg::CH_DQUOTE || c == jlex_pkg::CH_SQUOTE) begin
         // the other kind of quote is dropped
         if ((c == jlex_pkg::CH_SQUOTE) == quote_single_q) begin
            push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_STR, 8'd0);
            lex_mode_q     = jlex_pkg::MODE_IDLE;
            quote_single_q = 1'b0;
         end
      end else if (c == jlex_pkg::CH_BSLASH) begin
         lex_mode_q = jlex_pkg::MODE_ESC;
      end else begin
         push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, c);
      end
   endtask

   task automatic end_escape();
      lex_mode_q   = jlex_pkg::MODE_STR;
      esc_acc_q    = 8'd0;
      esc_digits_q = 2'd0;
   endtask

   task automatic predict_item(input logic [7:0] c, input logic end_mark);
      int base_count;
      int d;
      base_count = expected_events.size();
      if (end_mark) begin
         case (lex_mode_q)
            jlex_pkg::MODE_WS:
               push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_SPACE, 8'd0);
            jlex_pkg::MODE_DIGIT:
               push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_DIGIT, 8'd0);
            jlex_pkg::MODE_IDENT:
               push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_IDENT, 8'd0);
            jlex_pkg::MODE_SLASH: begin
               push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_PUNCT, jlex_pkg::CH_SLASH);
               push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_PUNCT, 8'd0);
            end
            jlex_pkg::MODE_STR, jlex_pkg::MODE_ESC, jlex_pkg::MODE_HEX,
            jlex_pkg::MODE_OCT:
               push_event(jlex_pkg::EV_DROP, jlex_pkg::TOK_STR, 8'd0);
            default: ;
         endcase
         clear_lexer();
      end else begin
         case (lex_mode_q)
            jlex_pkg::MODE_WS: begin
               if (blank_char(c)) push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_SPACE, c);
               else begin
                  push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_SPACE, 8'd0);
                  lex_mode_q = jlex_pkg::MODE_IDLE;
                  open_token(c);
               end
            end
            jlex_pkg::MODE_DIGIT: begin
               if (decimal_char(c)) push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_DIGIT, c);
               else begin
                  push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_DIGIT, 8'd0);
                  lex_mode_q = jlex_pkg::MODE_IDLE;
                  open_token(c);
               end
            end
            jlex_pkg::MODE_IDENT: begin
               if (name_lead(c) || decimal_char(c))
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_IDENT, c);
               else begin
                  push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_IDENT, 8'd0);
                  lex_mode_q = jlex_pkg::MODE_IDLE;
                  open_token(c);
               end
            end
            jlex_pkg::MODE_SLASH: begin
               lex_mode_q = jlex_pkg::MODE_IDLE;
               // comment openers vanish, a lone slash is punctuation
               if (c != jlex_pkg::CH_STAR && c != jlex_pkg::CH_SLASH) begin
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_PUNCT, jlex_pkg::CH_SLASH);
                  push_event(jlex_pkg::EV_CLOSE, jlex_pkg::TOK_PUNCT, 8'd0);
                  open_token(c);
               end
            end
            jlex_pkg::MODE_STR: string_byte(c);
            jlex_pkg::MODE_ESC: begin
               lex_mode_q = jlex_pkg::MODE_STR;
               if (c == jlex_pkg::CH_LOW_N)
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, jlex_pkg::CH_LF);
               else if (c == jlex_pkg::CH_LOW_R)
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, jlex_pkg::CH_CR);
               else if (c == jlex_pkg::CH_LOW_T)
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, jlex_pkg::CH_TAB);
               else if (c == jlex_pkg::CH_LOW_X) begin
                  lex_mode_q   = jlex_pkg::MODE_HEX;
                  esc_acc_q    = 8'd0;
                  esc_digits_q = 2'd0;
               end else if (octal_char(c)) begin
                  lex_mode_q   = jlex_pkg::MODE_OCT;
                  esc_acc_q    = {5'd0, c[2:0]};
                  esc_digits_q = 2'd1;
               end else push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, c);
            end
            jlex_pkg::MODE_HEX: begin
               d = hex_digit(c);
               if (d >= 0) begin
                  esc_acc_q    = {esc_acc_q[3:0], 4'(d)};
                  esc_digits_q = 2'd1;
               end else begin
                  // no digit read means the x itself is kept
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR,
                             (esc_digits_q != 0) ? esc_acc_q : jlex_pkg::CH_LOW_X);
                  end_escape();
                  string_byte(c);
               end
            end
            jlex_pkg::MODE_OCT: begin
               if (octal_char(c) && esc_digits_q < jlex_pkg::OCT_DIGITS) begin
                  esc_acc_q    = {esc_acc_q[4:0], c[2:0]};
                  esc_digits_q = esc_digits_q + 2'd1;
                  if (esc_digits_q >= jlex_pkg::OCT_DIGITS) begin
                     push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, esc_acc_q);
                     end_escape();
                  end
               end else begin
                  push_event(jlex_pkg::EV_CHAR, jlex_pkg::TOK_STR, esc_acc_q);
                  end_escape();
                  string_byte(c);
               end
            end
            default: begin
               lex_mode_q = jlex_pkg::MODE_IDLE;
               open_token(c);
            end
         endcase
      end
      if (expected_events.size() > base_count)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      lex_event_type got;
      lex_event_type want;
      if (reset) begin
         clear_lexer();
         expected_events.delete();
         event_errors = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_item(req_bus.byte_in, req_bus.end_mark);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.ev   = rsp_bus.event_kind;
            got.kind = rsp_bus.token_kind;
            got.ch   = rsp_bus.char_value;
            got.last = rsp_bus.last_of_run;
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event ev=%0d tok=%0d ch=%02h last=%0d", $time,
                        got.ev, got.kind, got.ch, got.last);
               event_errors = event_errors + 1;
            end else begin
               want = expected_events.pop_front();
               if (got.ev !== want.ev || got.kind !== want.kind ||
                   got.ch !== want.ch || got.last !== want.last) begin
                  $display("%0t: event mismatch, expected ev=%0d tok=%0d ch=%02h last=%0d",
                           $time, want.ev, want.kind, want.ch, want.last);
                  $display("%0t:                 actual   ev=%0d tok=%0d ch=%02h last=%0d",
                           $time, got.ev, got.kind, got.ch, got.last);
                  event_errors = event_errors + 1;
               end
            end
         end
      end
      events_pending = expected_events.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives byte items into the json lexer with random idling on both sides,
// a directed opening and random text, and reports the verdict
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ITEMS = 480;
   localparam int CALM_TAIL    = 60;
   localparam int LONG_HOLD    = 120;
   localparam int DRAIN_LIMIT  = 20000;

   logic clock;
   logic reset;

   jlex_req_if req_bus ();
   jlex_rsp_if rsp_bus ();

   int unsigned events_pending;
   int unsigned event_errors;

   logic [8:0] byte_stream[$];   // bit 8 is the end mark
   logic       hold_request;
   logic       hold_done;
   logic       calm_tail;
   logic       stuck;

   json_lexer_byte_stream_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   jlex_event_monitor event_mon (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .events_pending (events_pending),
      .event_errors   (event_errors)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic add_word(input logic [8:0] w);
      byte_stream = {byte_stream, w};
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_word({1'b0, b});
   endtask

   task automatic add_end();
      add_word({1'b1, 8'($urandom_range(0, 255))});
   endtask

   function automatic logic [7:0] pick_letter();
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] pick_name_char();
      case ($urandom_range(0, 5))
         0: return jlex_pkg::CH_USCORE;
         1: return jlex_pkg::CH_DOLLAR;
         2: return 8'h30 + 8'($urandom_range(0, 9));
         default: return pick_letter();
      endcase
   endfunction

   function automatic logic [7:0] pick_punct();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(33, 47));
         1: return 8'($urandom_range(58, 64));
         2: return 8'($urandom_range(91, 96));
         default: return 8'($urandom_range(123, 126));
      endcase
   endfunction

   function automatic logic [7:0] pick_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
   endfunction

   // one piece of string body: plain byte, other quote or an escape
   task automatic add_string_part(input logic single);
      logic [7:0] b;
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            b = 8'($urandom_range(0, 255));
            if (b == jlex_pkg::CH_BSLASH || b == jlex_pkg::CH_DQUOTE ||
                b == jlex_pkg::CH_SQUOTE) b = 8'h61;
            add_byte(b);
         end
         3: add_byte(single ? jlex_pkg::CH_DQUOTE : jlex_pkg::CH_SQUOTE);
         4: begin
            add_byte(jlex_pkg::CH_BSLASH);
            case ($urandom_range(0, 2))
               0: add_byte(jlex_pkg::CH_LOW_N);
               1: add_byte(jlex_pkg::CH_LOW_R);
               default: add_byte(jlex_pkg::CH_LOW_T);
            endcase
         end
         5, 6: begin
            add_byte(jlex_pkg::CH_BSLASH);
            add_byte(jlex_pkg::CH_LOW_X);
            n = $urandom_range(0, 3);
            repeat (n) add_byte(pick_hex());
         end
         7, 8: begin
            add_byte(jlex_pkg::CH_BSLASH);
            n = $urandom_range(1, 4);
            repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 7)));
         end
         default: begin
            add_byte(jlex_pkg::CH_BSLASH);
            add_byte($urandom_range(0, 1)
                     ? (single ? jlex_pkg::CH_SQUOTE : jlex_pkg::CH_DQUOTE)
                     : 8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task automatic add_random_piece();
      int n;
      int pick;
      logic single;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         n = $urandom_range(1, 4);
         repeat (n) add_byte($urandom_range(0, 2) ? 8'd32 : 8'($urandom_range(9, 13)));
      end else if (pick < 24) begin
         n = $urandom_range(1, 5);
         repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
      end else if (pick < 36) begin
         add_byte($urandom_range(0, 3) ? pick_letter()
                  : ($urandom_range(0, 1) ? jlex_pkg::CH_USCORE : jlex_pkg::CH_DOLLAR));
         n = $urandom_range(0, 5);
         repeat (n) add_byte(pick_name_char());
      end else if (pick < 46) begin
         add_byte(pick_punct());
      end else if (pick < 52) begin
         add_byte(jlex_pkg::CH_SLASH);
         add_byte($urandom_range(0, 1) ? jlex_pkg::CH_STAR : jlex_pkg::CH_SLASH);
      end else if (pick < 86) begin
         single = 1'($urandom_range(0, 1));
         add_byte(single ? jlex_pkg::CH_SQUOTE : jlex_pkg::CH_DQUOTE);
         n = $urandom_range(0, 6);
         repeat (n) add_string_part(single);
         if (pick < 80) add_byte(single ? jlex_pkg::CH_SQUOTE : jlex_pkg::CH_DQUOTE);
         else begin
            // string left open, sometimes right after a backslash
            if ($urandom_range(0, 1)) add_byte(jlex_pkg::CH_BSLASH);
            add_end();
         end
      end else if (pick < 93) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
         add_byte($urandom_range(0, 1)
                  ? 8'($urandom_range(128, 255))
                  : ($urandom_range(0, 1) ? 8'd127 : 8'($urandom_range(0, 8))));
      end else begin
         add_end();
      end
   endtask

   task automatic drive_item(input logic [8:0] w);
      req_bus.valid    <= 1'b1;
      req_bus.byte_in  <= w[7:0];
      req_bus.end_mark <= w[8];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (events_pending != 0) @(negedge clock);
   endtask

   // result side: random stall bursts, one long hold on request
   initial begin
      int n;
      int stall_pct;
      rsp_bus.ready = 1'b0;
      hold_done     = 1'b0;
      stall_pct     = 20;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 50;
            endcase
         end
         if (hold_request && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
            n = 0;
         end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
            rsp_bus.ready <= 1'b0;
            n = $urandom_range(1, 14);
         end else begin
            rsp_bus.ready <= 1'b1;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(negedge clock);
      end
   end

   initial begin
      int directed_len;
      int gap_pct;
      int cycles;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.byte_in  = 8'd0;
      req_bus.end_mark = 1'b0;
      hold_request     = 1'b0;
      calm_tail        = 1'b0;
      stuck            = 1'b0;
      gap_pct          = 20;

      // directed opening: token kinds, comment openers, lone slash, escapes,
      // other quote, ignored byte, open string at end after a backslash
      add_byte(" ");  add_byte("0");  add_byte("_");  add_byte("Z");
      add_byte(jlex_pkg::CH_SLASH); add_byte(jlex_pkg::CH_STAR);
      add_byte(jlex_pkg::CH_SLASH); add_byte("{");
      add_byte(8'h00);
      add_byte(jlex_pkg::CH_SQUOTE); add_byte(jlex_pkg::CH_DQUOTE);
      add_byte(jlex_pkg::CH_BSLASH); add_byte(jlex_pkg::CH_LOW_X);
      add_byte(jlex_pkg::CH_UP_F); add_byte("g");
      add_byte(jlex_pkg::CH_BSLASH); add_byte("3"); add_byte("7"); add_byte("7");
      add_byte(jlex_pkg::CH_BSLASH); add_byte(jlex_pkg::CH_LOW_N); add_byte(8'hff);
      add_byte(jlex_pkg::CH_BSLASH); add_byte(jlex_pkg::CH_LOW_X);
      add_byte(jlex_pkg::CH_SQUOTE);
      add_byte(jlex_pkg::CH_SLASH); add_word({1'b1, 8'hff});
      add_byte(jlex_pkg::CH_DQUOTE); add_byte(jlex_pkg::CH_BSLASH);
      add_word({1'b1, 8'h00});
      directed_len = byte_stream.size();

      while (byte_stream.size() < directed_len + RANDOM_ITEMS) add_random_piece();
      add_end();

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < byte_stream.size(); i++) begin
         if (i == directed_len || i == directed_len + RANDOM_ITEMS / 2) wait_drained();
         if (i == directed_len + RANDOM_ITEMS / 4) hold_request = 1'b1;
         if (i >= byte_stream.size() - CALM_TAIL) calm_tail = 1'b1;
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 40;
            endcase
         end
         if (!calm_tail && !(hold_request && !hold_done) &&
             $urandom_range(0, 99) < gap_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         drive_item(byte_stream[i]);
      end

      req_bus.valid <= 1'b0;
      cycles = 0;
      while (events_pending != 0 && cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         cycles++;
      end
      stuck = (events_pending != 0);
      repeat (30) @(negedge clock);

      if (event_errors == 0 && !stuck) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/jlex_pkg.sv
rtl/core/jlex_ifs.sv
rtl/core/json_lexer_byte_stream_core.sv
tb/jlex_event_monitor.sv
tb/tb_top.sv
